/* rtl/c2p_pkg.sv */
// Shared types, constants and tables of the Cartesian-to-polar radar unit.
`default_nettype none
package c2p_pkg;

    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_ANGLE_ITER = 18;
    localparam int MAX_ITER       = 30;
    localparam int QUEUE_DEPTH    = 4;
    localparam int SQ_STAGES      = 32;
    localparam int DIV_STAGES     = 31;
    localparam int IN_W           = 128;
    localparam int OUT_W          = 88;

    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    typedef struct packed {
        logic [63:0]        sum;
        logic [63:0]        dmag;
        logic               dneg;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_qitem;

    // atan(2^-i) in Q2.30
    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/c2p_front.sv */
// Front end: takes input items, forms magnitudes, products, range square and dot product.
`default_nettype none
module c2p_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [c2p_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                               o_push,
    output c2p_pkg::t_qitem                    o_item,
    input  wire logic                          i_full
);
    import c2p_pkg::*;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    logic               r_v1, r_v2;
    logic [31:0]        r_ax, r_ay, r_avx, r_avy;
    logic               r_n1_1, r_n2_1, r_n1_2, r_n2_2;
    logic signed [31:0] r_px1, r_py1, r_px2, r_py2;
    logic [63:0]        r_pxx, r_pyy, r_m1, r_m2;
    logic               a1, a2;
    logic [31:0]        px, py, vx, vy;

    assign px = i_s_axis_tdata[31:0];
    assign py = i_s_axis_tdata[63:32];
    assign vx = i_s_axis_tdata[95:64];
    assign vy = i_s_axis_tdata[127:96];

    assign o_push          = r_v2 && !i_full;
    assign a2              = !r_v2 || o_push;
    assign a1              = !r_v1 || a2;
    assign o_s_axis_tready = a1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (a1) r_v1 <= i_s_axis_tvalid;
            if (a2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a1 && i_s_axis_tvalid) begin
            r_ax   <= abs32(px);
            r_ay   <= abs32(py);
            r_avx  <= abs32(vx);
            r_avy  <= abs32(vy);
            r_n1_1 <= px[31] != vx[31];
            r_n2_1 <= py[31] != vy[31];
            r_px1  <= px;
            r_py1  <= py;
        end
        if (a2 && r_v1) begin
            r_pxx  <= r_ax * r_ax;
            r_pyy  <= r_ay * r_ay;
            r_m1   <= r_ax * r_avx;
            r_m2   <= r_ay * r_avy;
            r_n1_2 <= r_n1_1;
            r_n2_2 <= r_n2_1;
            r_px2  <= r_px1;
            r_py2  <= r_py1;
        end
    end

    always_comb begin
        o_item.sum = r_pxx + r_pyy;
        o_item.px  = r_px2;
        o_item.py  = r_py2;
        if (r_n1_2 == r_n2_2) begin
            o_item.dmag = r_m1 + r_m2;
            o_item.dneg = r_n1_2;
        end else if (r_m1 >= r_m2) begin
            o_item.dmag = r_m1 - r_m2;
            o_item.dneg = r_n1_2;
        end else begin
            o_item.dmag = r_m2 - r_m1;
            o_item.dneg = r_n2_2;
        end
    end

endmodule
`default_nettype wire

/* rtl/c2p_fifo.sv */
// Short item queue between front end and back end.
`default_nettype none
module c2p_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = c2p_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    import c2p_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/c2p_back.sv */
// Back end: root, divider and CORDIC pipelines with output register.
`default_nettype none
module c2p_back #(
    parameter int FRAC_BITS        = c2p_pkg::DEF_FRAC_BITS,
    parameter int ANGLE_ITERATIONS = c2p_pkg::DEF_ANGLE_ITER
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_q_valid,
    input  c2p_pkg::t_qitem                 i_q_item,
    output logic                            o_q_pop,
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic [c2p_pkg::OUT_W-1:0]       o_m_axis_tdata,
    output logic [0:0]                      o_m_axis_tuser
);
    import c2p_pkg::*;

    localparam int SQN  = SQ_STAGES;
    localparam int DVN  = DIV_STAGES;
    localparam int MAIN = SQN + 1 + DVN;
    localparam int CN   = ANGLE_ITERATIONS;
    localparam int CDLY = MAIN - (CN + 7);
    localparam int SH   = 30 - FRAC_BITS;
    localparam logic signed [33:0] RND    = 34'sd1 <<< (SH - 1);
    localparam logic signed [33:0] PI_OUT = (PI_Q30 + RND) >>> SH;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] n;
    } t_sq;

    typedef struct packed {
        logic [63:0] rem;
        logic [30:0] q;
        logic [31:0] rho;
        logic        ovf;
        logic        dneg;
        logic        flag;
    } t_dv;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic               yz;
        logic               xn;
    } t_cn;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [33:0] z;
        logic               yz;
        logic               xn;
    } t_cr;

    function automatic t_sq sq_step(input t_sq s);
        t_sq         o;
        logic [33:0] r2;
        logic [33:0] tr;
        r2  = {s.rem[31:0], s.n[63:62]};
        tr  = {s.root, 2'b01};
        o.n = {s.n[61:0], 2'b00};
        if (r2 >= tr) begin
            o.rem  = r2 - tr;
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = r2;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input int b);
        t_dv         o;
        logic [63:0] d;
        o = s;
        d = {32'd0, s.rho} << b;
        if (s.rem >= d) begin
            o.rem  = s.rem - d;
            o.q[b] = 1'b1;
        end
        return o;
    endfunction

    function automatic t_cn cn_step(input t_cn s, input int sa);
        t_cn         o;
        logic [32:0] ax;
        logic [32:0] ay;
        o  = s;
        ax = s.x[32] ? 33'(-s.x) : 33'(s.x);
        ay = s.y[32] ? 33'(-s.y) : 33'(s.y);
        if ((ax >> (31 - sa)) == '0 && (ay >> (31 - sa)) == '0) begin
            o.x = s.x <<< sa;
            o.y = s.y <<< sa;
        end
        return o;
    endfunction

    function automatic t_cr cr_step(input t_cr s, input int i);
        t_cr                o;
        logic signed [34:0] xs;
        logic signed [34:0] ys;
        o  = s;
        xs = s.x >>> i;
        ys = s.y >>> i;
        if (!s.y[34]) begin
            o.x = s.x + ys;
            o.y = s.y - xs;
            o.z = s.z + atan_q30(i);
        end else begin
            o.x = s.x - ys;
            o.y = s.y + xs;
            o.z = s.z - atan_q30(i);
        end
        return o;
    endfunction

    logic                      adv;
    logic                      r_v [1:MAIN];
    t_sq                       r_sq [1:SQN];
    logic [63:0]               r_sq_dmag [1:SQN];
    logic                      r_sq_dneg [1:SQN];
    t_dv                       r_dv [0:DVN];
    t_cn                       r_cn [1:5];
    t_cr                       r_cr [0:CN];
    logic [18:0]               r_ph [0:CDLY];
    logic                      r_ov;
    logic [31:0]               r_range, r_rate;
    logic [18:0]               r_bear;
    logic                      r_flag;

    t_sq                       sq_in;
    t_dv                       dv_in;
    t_cn                       cn_in;
    t_cr                       cr_in;
    logic signed [33:0]        zf, zr;
    logic [18:0]               phi;
    logic [31:0]               rate;
    logic [31:0]               root;
    logic [31:0]               qx;

    assign adv     = !r_ov || i_m_axis_tready;
    assign o_q_pop = adv && i_q_valid;

    always_comb begin
        sq_in      = '0;
        sq_in.n    = i_q_item.sum;
        cn_in.x    = {i_q_item.px[31], i_q_item.px};
        cn_in.y    = {i_q_item.py[31], i_q_item.py};
        cn_in.yz   = i_q_item.py == '0;
        cn_in.xn   = i_q_item.px[31];

        root       = r_sq[SQN].root;
        dv_in.flag = root == '0;
        dv_in.rho  = dv_in.flag ? 32'd1 : root;
        dv_in.ovf  = r_sq_dmag[SQN] >= ({32'd0, dv_in.rho} << 31);
        dv_in.rem  = r_sq_dmag[SQN];
        dv_in.q    = '0;
        dv_in.dneg = r_sq_dneg[SQN];

        cr_in.yz   = r_cn[5].yz;
        cr_in.xn   = r_cn[5].xn;
        if (r_cn[5].x[32]) begin
            cr_in.z = r_cn[5].y[32] ? -PI_Q30 : PI_Q30;
            cr_in.x = -{{2{r_cn[5].x[32]}}, r_cn[5].x};
            cr_in.y = -{{2{r_cn[5].y[32]}}, r_cn[5].y};
        end else begin
            cr_in.z = '0;
            cr_in.x = {{2{r_cn[5].x[32]}}, r_cn[5].x};
            cr_in.y = {{2{r_cn[5].y[32]}}, r_cn[5].y};
        end

        if (r_cr[CN].yz) zf = r_cr[CN].xn ? PI_Q30 : 34'sd0;
        else             zf = r_cr[CN].z;
        zr = (zf + RND) >>> SH;
        if (zr > PI_OUT)       phi = PI_OUT[18:0];
        else if (zr < -PI_OUT) phi = 19'(-PI_OUT);
        else                   phi = zr[18:0];

        qx = {1'b0, r_dv[DVN].q};
        if (r_dv[DVN].ovf) rate = r_dv[DVN].dneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else               rate = r_dv[DVN].dneg ? (~qx + 32'd1) : qx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= MAIN; k++) r_v[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v[1] <= i_q_valid;
            for (int k = 2; k <= MAIN; k++) r_v[k] <= r_v[k-1];
            r_ov <= r_v[MAIN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[1]      <= sq_step(sq_in);
            r_sq_dmag[1] <= i_q_item.dmag;
            r_sq_dneg[1] <= i_q_item.dneg;
            for (int k = 2; k <= SQN; k++) begin
                r_sq[k]      <= sq_step(r_sq[k-1]);
                r_sq_dmag[k] <= r_sq_dmag[k-1];
                r_sq_dneg[k] <= r_sq_dneg[k-1];
            end
            r_dv[0] <= dv_in;
            for (int k = 1; k <= DVN; k++) r_dv[k] <= dv_step(r_dv[k-1], DVN - k);

            r_cn[1] <= cn_step(cn_in, 16);
            for (int k = 2; k <= 5; k++) r_cn[k] <= cn_step(r_cn[k-1], 1 << (5 - k));
            r_cr[0] <= cr_in;
            for (int k = 1; k <= CN; k++) r_cr[k] <= cr_step(r_cr[k-1], k - 1);
            r_ph[0] <= phi;
            for (int k = 1; k <= CDLY; k++) r_ph[k] <= r_ph[k-1];

            r_range <= r_dv[DVN].rho;
            r_bear  <= r_dv[DVN].flag ? 19'd0 : r_ph[CDLY];
            r_rate  <= rate;
            r_flag  <= r_dv[DVN].flag;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'd0, r_rate, r_bear, r_range};
    assign o_m_axis_tuser  = r_flag;

`ifndef NO_ASSERTIONS
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_flag) |-> (r_range == 32'd1 && r_bear == '0 && r_rate == '0))
        else $error("origin item with nonzero fields");
    a_pop_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (adv && i_q_valid)) else $error("queue popped during stall");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[MAIN] && !adv) |=> r_v[MAIN]) else $error("item lost in stalled pipeline");
`endif

endmodule
`default_nettype wire

/* rtl/cartesian_to_polar_radar_unit.sv */
// Top level of the Cartesian-to-polar radar measurement unit.
//  channel  dir  tdata (low bit up)                         tuser
//  s_axis   in   pos_x[31:0] pos_y vel_x vel_y (128 bits)   -
//  m_axis   out  range_out[31:0] bearing_out[18:0]          near_origin
//                range_rate_out[31:0], 5 zero bits (88)
// One item per cycle sustained while the output is not stalled; the main path is the
// 32-step square root followed by the 31-step restoring divider.
// Synchronous active-low reset clears all valid state.
// A stalled output holds the back end; the front end runs on into the queue.
`default_nettype none
module cartesian_to_polar_radar_unit #(
    parameter int FRAC_BITS        = c2p_pkg::DEF_FRAC_BITS,
    parameter int ANGLE_ITERATIONS = c2p_pkg::DEF_ANGLE_ITER
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  wire logic [c2p_pkg::IN_W-1:0] i_s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    output logic [c2p_pkg::OUT_W-1:0]     o_m_axis_tdata,   // range, bearing, range rate
    output logic [0:0]                    o_m_axis_tuser    // near_origin
);
    import c2p_pkg::*;

    localparam int QW = $bits(t_qitem);

    t_qitem          f_item, q_item;
    logic [QW-1:0]   q_data;
    logic            push, full, pop, empty;

    c2p_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_push          (push),
        .o_item          (f_item),
        .i_full          (full)
    );

    c2p_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_data)
    );

    assign q_item = q_data;

    c2p_back #(
        .FRAC_BITS        (FRAC_BITS),
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (!empty),
        .i_q_item        (q_item),
        .o_q_pop         (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire
